// ----- rtl/nmea_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA position parser package
// Shared types, codes and constants of the GGA/RMC position parser.
// ----------------------------------------------------------------------------
package nmea_pkg;

    localparam int BYTE_W      = 8;
    localparam int OUT_DATA_W  = 168;
    localparam int EVQ_DEPTH   = 4;
    localparam int EVQ_AW      = $clog2(EVQ_DEPTH);
    localparam int PEND_SLOTS  = 8;
    localparam logic [3:0] MAX_FIELDS = 4'd14;

    // Letter mark of a field: nothing, exactly "S" or "W", exactly "A".
    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_SW   = 2'd1;
    localparam logic [1:0] MARK_A    = 2'd2;

    typedef struct packed {
        logic [4:0]  len;
        logic [1:0]  mark;
        logic        neg;
        logic [23:0] frac;
        logic [31:0] ival;
    } rec_t;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_FIELD = 2'd1,
        EV_END   = 2'd2
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [2:0] slot;
        logic       is_rmc;
        logic [3:0] fnum;
        rec_t       rec;
    } ev_t;

    function automatic logic [23:0] pow10(input logic [2:0] n);
        logic [23:0] r;
        unique case (n)
            3'd0: r = 24'd1;
            3'd1: r = 24'd10;
            3'd2: r = 24'd100;
            3'd3: r = 24'd1000;
            3'd4: r = 24'd10000;
            3'd5: r = 24'd100000;
            3'd6: r = 24'd1000000;
            3'd7: r = 24'd10000000;
            default: r = 24'd1;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/nmea_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA byte front end
// Matches the sentence header, accumulates decimal fields between commas and
// issues start, field and end events toward the commit unit.
// ----------------------------------------------------------------------------
module nmea_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [nmea_pkg::BYTE_W-1:0] s_tdata,
    output logic                        ev_valid,
    output nmea_pkg::ev_t               ev,
    input  logic                        ev_ready
);

    localparam logic [2:0] HDR_DONE   = 3'd5;
    localparam logic [2:0] HDR_REJECT = 3'd7;
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_GGA  = 2'd1;
    localparam logic [1:0] ST_RMC  = 2'd2;

    logic        in_s_reg, in_s_next;
    logic [2:0]  hdr_reg, hdr_next;
    logic [1:0]  st_reg, st_next;
    logic [3:0]  fnum_reg, fnum_next;
    logic [6:0]  flen_reg, flen_next;
    logic [31:0] iacc_reg, iacc_next;
    logic [23:0] facc_reg, facc_next;
    logic [2:0]  fdig_reg, fdig_next;
    logic        point_reg, point_next;
    logic        neg_reg, neg_next;
    logic [1:0]  mark_reg, mark_next;

    logic        accept;
    logic [7:0]  c;
    logic [35:0] iprod;
    logic [3:0]  dig;
    logic [47:0] f7_full;
    logic [2:0]  slot;
    logic        slot_ok;

    assign s_tready = ev_ready;
    assign accept   = s_tvalid && ev_ready;
    assign c        = s_tdata;
    assign dig      = 4'(c - 8'h30);
    assign iprod    = {4'd0, iacc_reg} * 36'd10 + 36'(dig);
    assign f7_full  = 48'(facc_reg) * 48'(nmea_pkg::pow10(3'(3'd7 - fdig_reg)));

    always_comb begin
        slot_ok = 1'b0;
        slot    = 3'd0;
        if (st_reg == ST_GGA) begin
            slot_ok = (fnum_reg >= 4'd2) && (fnum_reg <= 4'd9);
            slot    = 3'(fnum_reg - 4'd2);
        end else begin
            priority case (fnum_reg)
                4'd1: begin slot_ok = 1'b1; slot = 3'd1; end
                4'd2: begin slot_ok = 1'b1; slot = 3'd0; end
                4'd7: begin slot_ok = 1'b1; slot = 3'd5; end
                4'd9: begin slot_ok = 1'b1; slot = 3'd7; end
                default: ;
            endcase
        end
    end

    always_comb begin
        in_s_next  = in_s_reg;
        hdr_next   = hdr_reg;
        st_next    = st_reg;
        fnum_next  = fnum_reg;
        flen_next  = flen_reg;
        iacc_next  = iacc_reg;
        facc_next  = facc_reg;
        fdig_next  = fdig_reg;
        point_next = point_reg;
        neg_next   = neg_reg;
        mark_next  = mark_reg;
        ev_valid   = 1'b0;
        ev         = '0;
        ev.kind    = nmea_pkg::EV_START;
        if (accept) begin
            if (c == 8'h24) begin
                in_s_next  = 1'b1;
                hdr_next   = 3'd0;
                st_next    = ST_NONE;
                fnum_next  = 4'd0;
                flen_next  = 7'd0;
                iacc_next  = 32'd0;
                facc_next  = 24'd0;
                fdig_next  = 3'd0;
                point_next = 1'b0;
                neg_next   = 1'b0;
                mark_next  = nmea_pkg::MARK_NONE;
                ev_valid   = 1'b1;
            end else if (in_s_reg) begin
                if (c == 8'h0A) begin
                    in_s_next = 1'b0;
                    if (hdr_reg == HDR_DONE) begin
                        ev_valid  = 1'b1;
                        ev.kind   = nmea_pkg::EV_END;
                        ev.is_rmc = (st_reg != ST_GGA);
                        ev.fnum   = fnum_reg;
                    end
                end else if (hdr_reg < HDR_DONE) begin
                    hdr_next = HDR_REJECT;
                    unique case (hdr_reg)
                        3'd0: if (c == 8'h47) hdr_next = 3'd1;
                        3'd1: if (c == 8'h50 || c == 8'h4E) hdr_next = 3'd2;
                        3'd2: begin
                            if (c == 8'h47) begin
                                st_next  = ST_GGA;
                                hdr_next = 3'd3;
                            end else if (c == 8'h52) begin
                                st_next  = ST_RMC;
                                hdr_next = 3'd3;
                            end
                        end
                        3'd3: if ((st_reg == ST_GGA && c == 8'h47) ||
                                  (st_reg == ST_RMC && c == 8'h4D)) hdr_next = 3'd4;
                        3'd4: if ((st_reg == ST_GGA && c == 8'h41) ||
                                  (st_reg == ST_RMC && c == 8'h43)) hdr_next = HDR_DONE;
                        default: ;
                    endcase
                    if (hdr_next == HDR_REJECT) st_next = ST_NONE;
                end else if (hdr_reg == HDR_DONE) begin
                    if (c == 8'h2C) begin
                        if (slot_ok) begin
                            ev_valid      = 1'b1;
                            ev.kind       = nmea_pkg::EV_FIELD;
                            ev.slot       = slot;
                            ev.rec.ival   = iacc_reg;
                            ev.rec.frac   = f7_full[23:0];
                            ev.rec.neg    = neg_reg;
                            ev.rec.mark   = mark_reg;
                            ev.rec.len    = (flen_reg > 7'd31) ? 5'd31 : flen_reg[4:0];
                        end
                        if (fnum_reg < nmea_pkg::MAX_FIELDS) fnum_next = fnum_reg + 4'd1;
                        flen_next  = 7'd0;
                        iacc_next  = 32'd0;
                        facc_next  = 24'd0;
                        fdig_next  = 3'd0;
                        point_next = 1'b0;
                        neg_next   = 1'b0;
                        mark_next  = nmea_pkg::MARK_NONE;
                    end else begin
                        if (c >= 8'h30 && c <= 8'h39) begin
                            if (point_reg) begin
                                if (fdig_reg < 3'd7) begin
                                    facc_next = 24'(facc_reg * 24'd10 + 24'(dig));
                                    fdig_next = fdig_reg + 3'd1;
                                end
                            end else begin
                                iacc_next = (iprod > 36'hFFFFFFFF) ? 32'hFFFFFFFF
                                                                   : iprod[31:0];
                            end
                        end else if (c == 8'h2E) begin
                            point_next = 1'b1;
                        end else if (c == 8'h2D && flen_reg == 7'd0) begin
                            neg_next = 1'b1;
                        end
                        if (flen_reg == 7'd0) begin
                            if (c == 8'h53 || c == 8'h57) mark_next = nmea_pkg::MARK_SW;
                            else if (c == 8'h41) mark_next = nmea_pkg::MARK_A;
                            else mark_next = nmea_pkg::MARK_NONE;
                        end else begin
                            mark_next = nmea_pkg::MARK_NONE;
                        end
                        if (flen_reg < 7'd127) flen_next = flen_reg + 7'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_s_reg  <= 1'b0;
            hdr_reg   <= 3'd0;
            st_reg    <= ST_NONE;
            fnum_reg  <= 4'd0;
            flen_reg  <= 7'd0;
            iacc_reg  <= 32'd0;
            facc_reg  <= 24'd0;
            fdig_reg  <= 3'd0;
            point_reg <= 1'b0;
            neg_reg   <= 1'b0;
            mark_reg  <= nmea_pkg::MARK_NONE;
        end else begin
            in_s_reg  <= in_s_next;
            hdr_reg   <= hdr_next;
            st_reg    <= st_next;
            fnum_reg  <= fnum_next;
            flen_reg  <= flen_next;
            iacc_reg  <= iacc_next;
            facc_reg  <= facc_next;
            fdig_reg  <= fdig_next;
            point_reg <= point_next;
            neg_reg   <= neg_next;
            mark_reg  <= mark_next;
        end
    end

endmodule

// ----- rtl/nmea_evq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA event queue
// Small first-in first-out queue between the byte front end and the commit
// unit.
// ----------------------------------------------------------------------------
module nmea_evq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  nmea_pkg::ev_t in_ev,
    output logic          out_valid,
    input  logic          out_ready,
    output nmea_pkg::ev_t out_ev
);

    localparam int AW = nmea_pkg::EVQ_AW;

    nmea_pkg::ev_t mem [nmea_pkg::EVQ_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(nmea_pkg::EVQ_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_ev    = mem[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= in_ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ----- rtl/nmea_commit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA commit unit
// Stores field records of the current sentence and, at its end, updates the
// kept fix record step by step and presents it on the result register.
// ----------------------------------------------------------------------------
module nmea_commit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ev_valid,
    output logic                            ev_ready,
    input  nmea_pkg::ev_t                   ev,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nmea_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tuser
);

    typedef enum logic [3:0] {
        S_IDLE, S_GCHK, S_P0, S_P1, S_P2, S_P3, S_P4,
        S_M0, S_M1, S_R0, S_R1, S_R2, S_EMIT
    } state_t;

    state_t state_reg;
    nmea_pkg::rec_t pend_reg [nmea_pkg::PEND_SLOTS];

    logic        is_rmc_reg;
    logic [3:0]  fnum_reg;
    logic        sel_reg;
    logic [25:0] q_reg;
    logic [6:0]  rem_reg;
    logic [7:0]  qc_reg;
    logic [29:0] num_reg;
    logic [31:0] degs_reg;
    logic [24:0] min_reg;
    logic [7:0]  hf_reg;
    logic [4:0]  af_reg;
    logic [13:0] hint_reg;
    logic [19:0] aint_reg;
    logic [27:0] st_reg;
    logic [10:0] kc_reg;
    logic [11:0] sf_reg;

    logic        k_fix_reg;
    logic [30:0] k_lat_reg;
    logic [31:0] k_lon_reg;
    logic [20:0] k_alt_reg;
    logic [6:0]  k_sat_reg;
    logic [13:0] k_hdop_reg;
    logic [20:0] k_spd_reg;
    logic [17:0] k_time_reg;
    logic [18:0] k_date_reg;

    logic                            m_tvalid_reg;
    logic [nmea_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                            m_tuser_reg;

    nmea_pkg::rec_t pr, pd;
    logic [63:0] prod100;
    logic [61:0] prod60;
    logic [32:0] pos_sum;
    logic [31:0] pos_lim, pos_mag, pos_val;
    logic        pos_neg;
    logic [51:0] hprod, aprod;
    logic [25:0] hx, ax;
    logic [35:0] sx;
    logic [55:0] sprod;
    logic [20:0] hv;
    logic [23:0] av;
    logic [21:0] kv;

    assign ev_ready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign pr      = sel_reg ? pend_reg[2] : pend_reg[0];
    assign pd      = sel_reg ? pend_reg[3] : pend_reg[1];
    assign prod100 = 64'(pr.ival) * 64'(32'h51EB851F);
    assign prod60  = 62'(num_reg) * 62'(32'h88888889);
    assign pos_sum = 33'(degs_reg) + 33'(min_reg);
    assign pos_lim = sel_reg ? 32'd1800000000 : 32'd900000000;
    assign pos_mag = (pr.len < 5'd4) ? 32'd0 :
                     (pos_sum > 33'(pos_lim)) ? pos_lim : pos_sum[31:0];
    assign pos_neg = pr.neg ^ (pd.mark == nmea_pkg::MARK_SW);
    assign pos_val = pos_neg ? (~pos_mag + 32'd1) : pos_mag;

    // Rounded fraction terms use reciprocal multiplies for /100000 and /1000000.
    assign hx    = 26'(pend_reg[6].frac) + 26'd50000;
    assign ax    = 26'(pend_reg[7].frac) + 26'd500000;
    assign hprod = 52'(hx) * 52'(26'd43980466);
    assign aprod = 52'(ax) * 52'(26'd35184373);
    assign sx    = 36'(pend_reg[5].frac) * 36'd1852 + 36'd5000000;
    assign sprod = 56'(st_reg) * 56'(28'd225179982);
    assign hv    = 21'(hint_reg) * 21'd100 + 21'(hf_reg);
    assign av    = 24'(aint_reg) * 24'd10 + 24'(af_reg);
    assign kv    = 22'(kc_reg) * 22'd1852 + 22'(sf_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < nmea_pkg::PEND_SLOTS; i++) pend_reg[i] <= '0;
            k_fix_reg    <= 1'b0;
            k_lat_reg    <= '0;
            k_lon_reg    <= '0;
            k_alt_reg    <= '0;
            k_sat_reg    <= '0;
            k_hdop_reg   <= '0;
            k_spd_reg    <= '0;
            k_time_reg   <= '0;
            k_date_reg   <= '0;
        end else begin
            // In S_EMIT the result register is reloaded or held below instead.
            if (m_tvalid_reg && m_tready && state_reg != S_EMIT) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (ev_valid) begin
                        unique case (ev.kind)
                            nmea_pkg::EV_START: begin
                                for (int i = 0; i < nmea_pkg::PEND_SLOTS; i++)
                                    pend_reg[i] <= '0;
                            end
                            nmea_pkg::EV_FIELD: pend_reg[ev.slot] <= ev.rec;
                            nmea_pkg::EV_END: begin
                                is_rmc_reg <= ev.is_rmc;
                                fnum_reg   <= ev.fnum;
                                state_reg  <= ev.is_rmc ? S_R0 : S_GCHK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_GCHK: begin
                    if (fnum_reg < 4'd6) begin
                        state_reg <= S_EMIT;
                    end else if (pend_reg[4].ival == 32'd0 || pend_reg[4].neg) begin
                        k_fix_reg <= 1'b0;
                        state_reg <= S_EMIT;
                    end else begin
                        k_fix_reg <= 1'b1;
                        if (pend_reg[0].len != 5'd0) begin
                            sel_reg   <= 1'b0;
                            state_reg <= S_P0;
                        end else if (pend_reg[2].len != 5'd0) begin
                            sel_reg   <= 1'b1;
                            state_reg <= S_P0;
                        end else begin
                            state_reg <= S_M0;
                        end
                    end
                end
                S_P0: begin
                    q_reg     <= prod100[62:37];
                    state_reg <= S_P1;
                end
                S_P1: begin
                    rem_reg   <= 7'(pr.ival - 32'(q_reg) * 32'd100);
                    qc_reg    <= (q_reg > 26'd255) ? 8'd255 : q_reg[7:0];
                    state_reg <= S_P2;
                end
                S_P2: begin
                    num_reg   <= 30'(rem_reg) * 30'd10000000 + 30'(pr.frac) + 30'd30;
                    degs_reg  <= 32'(qc_reg) * 32'd10000000;
                    state_reg <= S_P3;
                end
                S_P3: begin
                    min_reg   <= prod60[61:37];
                    state_reg <= S_P4;
                end
                S_P4: begin
                    if (sel_reg) k_lon_reg <= pos_val;
                    else k_lat_reg <= pos_val[30:0];
                    if (!sel_reg && pend_reg[2].len != 5'd0) begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_P0;
                    end else begin
                        state_reg <= S_M0;
                    end
                end
                S_M0: begin
                    if (fnum_reg >= 4'd7) begin
                        if (pend_reg[5].neg && pend_reg[5].ival != 32'd0) k_sat_reg <= 7'd0;
                        else if (pend_reg[5].ival > 32'd99) k_sat_reg <= 7'd99;
                        else k_sat_reg <= pend_reg[5].ival[6:0];
                    end
                    hf_reg    <= hprod[49:42];
                    af_reg    <= aprod[49:45];
                    hint_reg  <= (pend_reg[6].ival > 32'd10000) ? 14'd10000
                                                                : pend_reg[6].ival[13:0];
                    aint_reg  <= (pend_reg[7].ival > 32'd1000001) ? 20'd1000001
                                                                  : pend_reg[7].ival[19:0];
                    state_reg <= S_M1;
                end
                S_M1: begin
                    if (fnum_reg >= 4'd8) begin
                        if (pend_reg[6].neg && hv != 21'd0) k_hdop_reg <= 14'd0;
                        else if (hv > 21'd9999) k_hdop_reg <= 14'd9999;
                        else k_hdop_reg <= hv[13:0];
                    end
                    if (fnum_reg >= 4'd9) begin
                        if (pend_reg[7].neg) begin
                            k_alt_reg <= (av > 24'd100000) ? 21'(-21'sd100000)
                                                           : 21'(~av + 24'd1);
                        end else begin
                            k_alt_reg <= (av > 24'd1000000) ? 21'd1000000 : av[20:0];
                        end
                    end
                    state_reg <= S_EMIT;
                end
                S_R0: begin
                    if (fnum_reg < 4'd7 || pend_reg[0].mark != nmea_pkg::MARK_A) begin
                        state_reg <= S_EMIT;
                    end else begin
                        st_reg    <= sx[34:7];
                        kc_reg    <= (pend_reg[5].ival > 32'd2047) ? 11'd2047
                                                                   : pend_reg[5].ival[10:0];
                        state_reg <= S_R1;
                    end
                end
                S_R1: begin
                    sf_reg    <= sprod[55:44];
                    state_reg <= S_R2;
                end
                S_R2: begin
                    if (pend_reg[5].len != 5'd0) begin
                        if (pend_reg[5].neg && kv != 22'd0) k_spd_reg <= 21'd0;
                        else if (kv > 22'd2000000) k_spd_reg <= 21'd2000000;
                        else k_spd_reg <= kv[20:0];
                    end
                    if (pend_reg[1].neg && pend_reg[1].ival != 32'd0) k_time_reg <= 18'd0;
                    else if (pend_reg[1].ival > 32'd235959) k_time_reg <= 18'd235959;
                    else k_time_reg <= pend_reg[1].ival[17:0];
                    if (pend_reg[7].neg && pend_reg[7].ival != 32'd0) k_date_reg <= 19'd0;
                    else if (pend_reg[7].ival > 32'd311299) k_date_reg <= 19'd311299;
                    else k_date_reg <= pend_reg[7].ival[18:0];
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= is_rmc_reg;
                        m_tdata_reg  <= {4'd0, k_date_reg, k_time_reg, k_spd_reg,
                                         k_hdop_reg, k_sat_reg, k_alt_reg, k_lon_reg,
                                         k_lat_reg, k_fix_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/nmea_gga_rmc_position_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA/RMC position parser
// Parses a byte stream of NMEA sentences and emits the kept fix record each
// time a GGA or RMC sentence ends.
//
//   port group   dir  contents
//   s_*          in   tdata[7:0] = rx_byte
//   m_*          out  tuser = sentence_kind; tdata = fix_valid[0],
//                     latitude_e7[31:1], longitude_e7[63:32], altitude_dm[84:64],
//                     satellite_count[91:85], hdop_centi[105:92],
//                     speed_milli_kmh[126:106], utc_time[144:127],
//                     utc_date[163:145], zeros[167:164]
//
// One byte is taken per cycle while s_tready is high; each byte yields at most
// one event into a four-entry queue. The commit unit takes one event per cycle,
// but a sentence end occupies it for its checks and multiply steps and then for
// loading the result register. A full queue or a held result stalls s_tready.
// Reset (aresetn low, synchronous) clears the parser state and the fix record.
// ----------------------------------------------------------------------------
module nmea_gga_rmc_position_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,  // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,  // fix_valid, latitude_e7 .. utc_date, zero pad
    output logic         m_tuser   // [0] sentence_kind
);

    logic          fe_valid, fe_ready, be_valid, be_ready;
    nmea_pkg::ev_t fe_ev, be_ev;

    nmea_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .ev_valid (fe_valid),
        .ev       (fe_ev),
        .ev_ready (fe_ready)
    );

    nmea_evq u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_ev     (fe_ev),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_ev    (be_ev)
    );

    nmea_commit u_commit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev_valid (be_valid),
        .ev_ready (be_ready),
        .ev       (be_ev),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/nmea_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA parser port checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nmea_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata,
    input logic         m_tuser
);

    // A result waiting for the sink holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Saturated counts stay in range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[91:85] <= 7'd99) && (m_tdata[105:92] <= 14'd9999))
        else $error("satellite count or hdop out of range");

    // The pad bits above the last field are always zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[167:164] == 4'd0))
        else $error("result padding not zero");

endmodule

bind nmea_gga_rmc_position_parser nmea_checker u_nmea_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA/RMC position parser testbench
// Feeds directed and random NMEA byte streams into the parser, predicts the
// kept fix record for every recognized sentence end and compares each result
// transfer field by field, under several phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic        kind;
        logic        fix_valid;
        logic [30:0] lat;
        logic [31:0] lon;
        logic [20:0] alt;
        logic [6:0]  sats;
        logic [13:0] hdop;
        logic [20:0] speed;
        logic [17:0] utc_t;
        logic [18:0] utc_d;
    } fix_t;

    localparam longint E7V = 64'd10000000;
    localparam int CYCLE_LIMIT = 200000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic         m_tuser;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  failures = 0;
    longint cycles = 0;
    fix_t expected_fixes[$];

    // Predictor state.
    logic           p_in, p_neg, p_point;
    logic [2:0]     p_hdr, p_fdig;
    logic [1:0]     p_type, p_mark;
    logic [3:0]     p_fnum;
    logic [6:0]     p_flen;
    logic [31:0]    p_int;
    logic [31:0]    p_frac;
    nmea_pkg::rec_t p_pend[8];
    fix_t           p_fix;

    nmea_gga_rmc_position_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic void clear_field();
        p_flen = 0; p_int = 0; p_frac = 0; p_fdig = 0; p_point = 0; p_neg = 0;
        p_mark = nmea_pkg::MARK_NONE;
    endfunction

    function automatic int slot_for(logic [3:0] f);
        if (p_type == 2'd1) return (f >= 2 && f <= 9) ? int'(f) - 2 : -1;
        case (f)
            4'd1: return 1;
            4'd2: return 0;
            4'd7: return 5;
            4'd9: return 7;
            default: return -1;
        endcase
    endfunction

    function automatic void close_field();
        int s;
        longint unsigned f7;
        longint unsigned pw;
        s = slot_for(p_fnum);
        if (s >= 0) begin
            pw = 1;
            for (int i = 0; i < 7 - p_fdig; i++) pw = pw * 10;
            f7 = longint'(p_frac) * pw;
            if (f7 > 64'hFFFFFF) f7 = 64'hFFFFFF;
            p_pend[s].ival = p_int;
            p_pend[s].frac = f7[23:0];
            p_pend[s].neg = p_neg;
            p_pend[s].mark = p_mark;
            p_pend[s].len = (p_flen > 31) ? 5'd31 : p_flen[4:0];
        end
        if (p_fnum < nmea_pkg::MAX_FIELDS) p_fnum++;
        clear_field();
    endfunction

    function automatic longint position_of(nmea_pkg::rec_t r, nmea_pkg::rec_t dir,
                                           longint lim);
        longint unsigned ip, v;
        logic neg;
        if (r.len < 4) return 0;
        ip = r.ival;
        v = (ip / 100) * E7V + (((ip % 100) * E7V + r.frac + 30) / 60);
        if (v > lim) v = lim;
        neg = r.neg != (dir.mark == nmea_pkg::MARK_SW);
        return neg ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint unsigned clamp_pos(nmea_pkg::rec_t r, longint unsigned v,
                                                  longint unsigned hi);
        if (r.neg && v != 0) return 0;
        return v > hi ? hi : v;
    endfunction

    function automatic void commit_gga();
        longint unsigned v;
        if (p_fnum < 6) return;
        if (p_pend[4].ival == 0 || p_pend[4].neg) begin
            p_fix.fix_valid = 1'b0;
            return;
        end
        p_fix.fix_valid = 1'b1;
        if (p_pend[0].len > 0) p_fix.lat = 31'(position_of(p_pend[0], p_pend[1], 900000000));
        if (p_pend[2].len > 0) p_fix.lon = 32'(position_of(p_pend[2], p_pend[3], 1800000000));
        if (p_fnum >= 7) p_fix.sats = 7'(clamp_pos(p_pend[5], p_pend[5].ival, 99));
        if (p_fnum >= 8) begin
            v = longint'(p_pend[6].ival) * 100 + (p_pend[6].frac + 50000) / 100000;
            p_fix.hdop = 14'(clamp_pos(p_pend[6], v, 9999));
        end
        if (p_fnum >= 9) begin
            v = longint'(p_pend[7].ival) * 10 + (p_pend[7].frac + 500000) / 1000000;
            if (p_pend[7].neg) p_fix.alt = (v > 100000) ? -21'sd100000 : 21'(-longint'(v));
            else p_fix.alt = (v > 1000000) ? 21'd1000000 : 21'(v);
        end
    endfunction

    function automatic void commit_rmc();
        longint unsigned k;
        if (p_fnum < 7 || p_pend[0].mark != nmea_pkg::MARK_A) return;
        if (p_pend[5].len > 0) begin
            k = p_pend[5].ival;
            if (k > E7V) k = E7V;
            k = ((k * E7V + p_pend[5].frac) * 1852 + E7V / 2) / E7V;
            p_fix.speed = 21'(clamp_pos(p_pend[5], k, 2000000));
        end
        p_fix.utc_t = 18'(clamp_pos(p_pend[1], p_pend[1].ival, 235959));
        p_fix.utc_d = 19'(clamp_pos(p_pend[7], p_pend[7].ival, 311299));
    endfunction

    function automatic void header_byte(logic [7:0] c);
        logic [2:0] nx;
        nx = 3'd7;
        case (p_hdr)
            3'd0: if (c == "G") nx = 3'd1;
            3'd1: if (c == "P" || c == "N") nx = 3'd2;
            3'd2: if (c == "G") begin
                p_type = 2'd1; nx = 3'd3;
            end else if (c == "R") begin
                p_type = 2'd2; nx = 3'd3;
            end
            3'd3: if ((p_type == 1 && c == "G") || (p_type == 2 && c == "M")) nx = 3'd4;
            3'd4: if ((p_type == 1 && c == "A") || (p_type == 2 && c == "C")) nx = 3'd5;
            default: ;
        endcase
        if (nx == 3'd7) p_type = 2'd0;
        p_hdr = nx;
    endfunction

    function automatic void body_byte(logic [7:0] c);
        longint unsigned v;
        if (c == ",") begin
            close_field();
            return;
        end
        if (c >= "0" && c <= "9") begin
            if (p_point) begin
                if (p_fdig < 7) begin
                    p_frac = p_frac * 10 + (c - "0");
                    p_fdig++;
                end
            end else begin
                v = longint'(p_int) * 10 + (c - "0");
                p_int = (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
            end
        end else if (c == ".") p_point = 1;
        else if (c == "-" && p_flen == 0) p_neg = 1;
        if (p_flen == 0) begin
            p_mark = (c == "S" || c == "W") ? nmea_pkg::MARK_SW :
                     (c == "A") ? nmea_pkg::MARK_A : nmea_pkg::MARK_NONE;
        end else begin
            p_mark = nmea_pkg::MARK_NONE;
        end
        if (p_flen < 127) p_flen++;
    endfunction

    // Advances the predictor by one received byte and queues any fix record.
    function automatic void predict_byte(logic [7:0] c);
        if (c == "$") begin
            p_in = 1; p_hdr = 0; p_type = 0; p_fnum = 0;
            clear_field();
            for (int i = 0; i < 8; i++) p_pend[i] = '0;
            return;
        end
        if (!p_in) return;
        if (c == 8'h0A) begin
            p_in = 0;
            if (p_hdr != 3'd5) return;
            if (p_type == 2'd1) commit_gga(); else commit_rmc();
            p_fix.kind = (p_type == 2'd1) ? 1'b0 : 1'b1;
            expected_fixes.push_back(p_fix);
            return;
        end
        if (p_hdr < 3'd5) header_byte(c);
        else if (p_hdr == 3'd5) body_byte(c);
    endfunction

    // Leaves s_tvalid high after the transfer; the next byte or an idle cycle
    // overwrites it, and drain() drops it at the end of a test.
    task automatic send_byte(input logic [7:0] c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Receiver: random stalls, and a field-by-field check of each transfer.
    always @(posedge aclk) begin
        fix_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            {got.utc_d, got.utc_t, got.speed, got.hdop, got.sats, got.alt, got.lon,
             got.lat, got.fix_valid} = m_tdata[163:0];
            if (expected_fixes.size() == 0) begin
                $error("unexpected result transfer");
                failures++;
            end else begin
                want = expected_fixes.pop_front();
                if (got.kind != want.kind) begin
                    $error("sentence_kind exp %0d got %0d", want.kind, got.kind); failures++;
                end
                if (got.fix_valid != want.fix_valid) begin
                    $error("fix_valid exp %0d got %0d", want.fix_valid, got.fix_valid);
                    failures++;
                end
                if (got.lat != want.lat) begin
                    $error("latitude_e7 exp %0d got %0d", $signed(want.lat), $signed(got.lat));
                    failures++;
                end
                if (got.lon != want.lon) begin
                    $error("longitude_e7 exp %0d got %0d", $signed(want.lon), $signed(got.lon));
                    failures++;
                end
                if (got.alt != want.alt) begin
                    $error("altitude_dm exp %0d got %0d", $signed(want.alt), $signed(got.alt));
                    failures++;
                end
                if (got.sats != want.sats) begin
                    $error("satellite_count exp %0d got %0d", want.sats, got.sats); failures++;
                end
                if (got.hdop != want.hdop) begin
                    $error("hdop_centi exp %0d got %0d", want.hdop, got.hdop); failures++;
                end
                if (got.speed != want.speed) begin
                    $error("speed_milli_kmh exp %0d got %0d", want.speed, got.speed);
                    failures++;
                end
                if (got.utc_t != want.utc_t) begin
                    $error("utc_time exp %0d got %0d", want.utc_t, got.utc_t); failures++;
                end
                if (got.utc_d != want.utc_d) begin
                    $error("utc_date exp %0d got %0d", want.utc_d, got.utc_d); failures++;
                end
            end
        end
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic string rand_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
        return s;
    endfunction

    // A numeric field, sometimes empty or signed, with a random integer part and sometimes a fraction part.
    function automatic string rand_number();
        string s;
        s = "";
        case ($urandom_range(9))
            0: return "";
            1: s = "-";
            default: ;
        endcase
        s = {s, rand_digits($urandom_range(1, ($urandom_range(9) == 0) ? 12 : 5))};
        if ($urandom_range(1)) s = {s, ".", rand_digits($urandom_range(0, 9))};
        return s;
    endfunction

    function automatic string rand_field();
        case ($urandom_range(7))
            0: return "S";
            1: return "W";
            2: return "A";
            3: return "N";
            default: return rand_number();
        endcase
    endfunction

    function automatic string rand_gga();
        string s;
        int nf;
        s = $urandom_range(1) ? "$GPGGA" : "$GNGGA";
        nf = ($urandom_range(4) == 0) ? $urandom_range(0, 16) : $urandom_range(9, 14);
        for (int i = 1; i <= nf; i++) begin
            case (i)
                2: s = {s, ",", rand_digits($urandom_range(2, 4)), ".", rand_digits(4)};
                3: s = {s, ",", $urandom_range(1) ? "S" : "N"};
                4: s = {s, ",", rand_digits($urandom_range(3, 5)), ".", rand_digits(4)};
                5: s = {s, ",", $urandom_range(1) ? "W" : "E"};
                6: s = {s, ",", ($urandom_range(5) == 0) ? rand_field() :
                        string'(8'("0" + $urandom_range(2)))};
                default: s = {s, ",", rand_field()};
            endcase
        end
        return {s, "*5A\n"};
    endfunction

    function automatic string rand_rmc();
        string s;
        int nf;
        s = $urandom_range(1) ? "$GPRMC" : "$GNRMC";
        nf = ($urandom_range(4) == 0) ? $urandom_range(0, 16) : $urandom_range(9, 12);
        for (int i = 1; i <= nf; i++) begin
            case (i)
                1: s = {s, ",", rand_digits(6), ".00"};
                2: s = {s, ",", ($urandom_range(4) == 0) ? "V" : "A"};
                9: s = {s, ",", rand_digits(6)};
                default: s = {s, ",", rand_field()};
            endcase
        end
        return {s, "\n"};
    endfunction

    function automatic string rand_noise();
        string s;
        int n;
        n = $urandom_range(1, 12);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(255)))};
        return s;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_fixes.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n");
        send_text("$GNGGA,0,9000.0000001,S,18000.00,W,2,150,99.999,-20000.5,M\n");
        send_text("$GPGGA,0,12,N,1,W,1,-3,-1.5,99999999.99\n");
        send_text("$GPGGA,1,2,3,4,5,0,7,8,9\n");
        send_text("$GPGGA,1,2,3\n");
        send_text("$GPRMC,235959.99,A,4807.038,N,01131.000,E,022.4,084.4,311299,,*6A\n");
        send_text("$GNRMC,999999,A,,,,,99999999999.1234567,,999999\n");
        send_text("$GPRMC,010203,V,1,2,3,4,5,6,7\n");
        send_text("$GPRMC,010203,AA,1,2,3,4,5,6,7\n");
        send_text("$GPRMC,-5,A,1,2,3,4,-0.5,6,-7\n");
        send_text("$GPXXX,1,2\n$GPG$GPGGA,,,,,,1\n\377\001$GPGSV,1\n");
        send_text("$GPGGA,1,2,3,4,5,1,7,8,9,10,11,12,13,14,15,16,17\n");
        drain();
    endtask

    task automatic test_random(input int n_bytes);
        int sent;
        string s;
        sent = 0;
        while (sent < n_bytes) begin
            case ($urandom_range(9))
                0, 1, 2, 3: s = rand_gga();
                4, 5, 6: s = rand_rmc();
                7: s = rand_noise();
                8: s = {rand_gga().substr(0, $urandom_range(3, 20)), rand_rmc()};
                default: s = {"\n", rand_noise(), "$", rand_noise(), "\n"};
            endcase
            send_text(s);
            sent += s.len();
        end
        drain();
    endtask

    task automatic test_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        test_random(n_bytes);
    endtask

    initial begin
        p_in = 0; p_hdr = 0; p_type = 0; p_fnum = 0;
        clear_field();
        for (int i = 0; i < 8; i++) p_pend[i] = '0;
        p_fix = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_phase(0, 0, 180);
        test_phase(56, 0, 180);
        test_phase(0, 56, 180);
        test_phase(37, 37, 180);
        if (failures == 0 && expected_fixes.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/nmea_pkg.sv
rtl/nmea_front.sv
rtl/nmea_evq.sv
rtl/nmea_commit.sv
rtl/nmea_gga_rmc_position_parser.sv
rtl/nmea_checker.sv
tb/tb.sv
